[rtl/core/assert_macros.svh]
// Assertion macros shared by the keypad code entry RTL.
// Included by modules that carry concurrent checks; empty when SYNTHESIS is set.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define KCEF_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define KCEF_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define KCEF_ASSERT(lbl, clk, rst_n, prop, msg)
`define KCEF_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

[rtl/core/kcef_pkg.sv]
// Shared constants and types for the keypad code entry block.
// No dependencies; imported by every module of the block.
package kcef_pkg;

    localparam int CODE_LENGTH = 6;
    localparam int PHASE_W     = 4;
    localparam int COUNT_W     = 3;
    localparam int KEY_W       = 8;
    localparam int TICK_W      = 16;
    localparam int CODE_W      = 48;

    localparam logic [KEY_W-1:0] KEY_NONE   = 8'h00;
    localparam logic [KEY_W-1:0] KEY_DELETE = 8'h23;
    localparam logic [KEY_W-1:0] KEY_ENTER  = 8'h2A;

    localparam logic REQ_KEY  = 1'b0;
    localparam logic REQ_TICK = 1'b1;

    localparam logic [PHASE_W-1:0] PH_IDLE       = 4'd0;
    localparam logic [PHASE_W-1:0] PH_ENTER      = PHASE_W'(CODE_LENGTH);
    localparam logic [PHASE_W-1:0] PH_COMPLETE   = PHASE_W'(CODE_LENGTH + 1);
    localparam logic [PHASE_W-1:0] PH_INCOMPLETE = PHASE_W'(CODE_LENGTH + 2);
    localparam logic [PHASE_W-1:0] PH_TIMEOUT    = PHASE_W'(CODE_LENGTH + 3);

    localparam logic [TICK_W-1:0] TICK_MAX      = 16'hFFFF;
    localparam logic [TICK_W-1:0] TIMEOUT_RESET = 16'd5000;

    typedef struct packed {
        logic [PHASE_W-1:0] phase;
        logic [COUNT_W-1:0] digits_held;
        logic [CODE_W-1:0]  entered_code;
    } result_t;

endpackage

[rtl/core/kcef_core.sv]
// Entry state machine: phase, digit store, tick timer and timeout register.
// Depends on kcef_pkg and assert_macros.svh.
`include "assert_macros.svh"
module kcef_core
    import kcef_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_we,
    input  logic [TICK_W-1:0]  cfg_wdata,
    input  logic               item_en,
    input  logic               req_type,
    input  logic [KEY_W-1:0]   key_code,
    output result_t            res_next
);

    logic [TICK_W-1:0]  timeout_reg;
    logic [PHASE_W-1:0] phase_reg,   phase_next;
    logic [COUNT_W-1:0] count_reg,   count_next;
    logic [TICK_W-1:0]  elapsed_reg, elapsed_next;
    logic [KEY_W-1:0]   store_reg  [CODE_LENGTH];
    logic [KEY_W-1:0]   store_next [CODE_LENGTH];

    always_comb begin
        logic [COUNT_W-1:0] dec;
        dec          = count_reg - COUNT_W'(1);
        phase_next   = phase_reg;
        count_next   = count_reg;
        elapsed_next = elapsed_reg;
        for (int i = 0; i < CODE_LENGTH; i++) begin
            store_next[i] = store_reg[i];
        end
        if (req_type == REQ_TICK) begin
            if (elapsed_reg != TICK_MAX) begin
                elapsed_next = elapsed_reg + TICK_W'(1);
            end
        end else if (key_code != KEY_NONE) begin
            if (phase_reg == PH_IDLE) begin
                if (key_code != KEY_DELETE && key_code != KEY_ENTER) begin
                    for (int i = 0; i < CODE_LENGTH; i++) begin
                        store_next[i] = (i == 0) ? key_code : '0;
                    end
                    count_next   = COUNT_W'(1);
                    elapsed_next = '0;
                    phase_next   = PHASE_W'(1);
                end
            end else if (phase_reg <= PH_ENTER) begin
                if (elapsed_reg >= timeout_reg) begin
                    phase_next = PH_TIMEOUT;
                end else if (key_code == KEY_DELETE) begin
                    if (count_reg != '0) begin
                        count_next = dec;
                        for (int i = 0; i < CODE_LENGTH; i++) begin
                            if (dec == COUNT_W'(i)) begin
                                store_next[i] = '0;
                            end
                        end
                    end
                    elapsed_next = '0;
                    phase_next   = phase_reg - PHASE_W'(1);
                end else if (key_code == KEY_ENTER) begin
                    phase_next = (phase_reg == PH_ENTER) ? PH_COMPLETE : PH_INCOMPLETE;
                end else if (phase_reg != PH_ENTER) begin
                    if (count_reg < COUNT_W'(CODE_LENGTH)) begin
                        for (int i = 0; i < CODE_LENGTH; i++) begin
                            if (count_reg == COUNT_W'(i)) begin
                                store_next[i] = key_code;
                            end
                        end
                        count_next = count_reg + COUNT_W'(1);
                    end
                    elapsed_next = '0;
                    phase_next   = phase_reg + PHASE_W'(1);
                end
            end else begin
                for (int i = 0; i < CODE_LENGTH; i++) begin
                    store_next[i] = '0;
                end
                count_next = '0;
                phase_next = PH_IDLE;
            end
        end
    end

    always_comb begin
        res_next.phase        = phase_next;
        res_next.digits_held  = count_next;
        res_next.entered_code = '0;
        for (int i = 0; i < CODE_LENGTH; i++) begin
            res_next.entered_code[i*KEY_W +: KEY_W] = store_next[i];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            timeout_reg <= TIMEOUT_RESET;
            phase_reg   <= PH_IDLE;
            count_reg   <= '0;
            elapsed_reg <= '0;
            for (int i = 0; i < CODE_LENGTH; i++) begin
                store_reg[i] <= '0;
            end
        end else begin
            if (cfg_we) begin
                timeout_reg <= cfg_wdata;
            end
            if (item_en) begin
                phase_reg   <= phase_next;
                count_reg   <= count_next;
                elapsed_reg <= elapsed_next;
                for (int i = 0; i < CODE_LENGTH; i++) begin
                    store_reg[i] <= store_next[i];
                end
            end
        end
    end

    `KCEF_ASSERT(a_idle_empty, aclk, aresetn, (phase_reg == PH_IDLE) |-> (count_reg == '0), "idle phase with digits held")
    `KCEF_ASSERT(a_count_max, aclk, aresetn, count_reg <= COUNT_W'(CODE_LENGTH), "digit count above code length")
    `KCEF_ASSERT(a_tick_hold, aclk, aresetn, (item_en && req_type == REQ_TICK) |=> $stable(phase_reg), "phase moved on a tick")
    `KCEF_ASSERT(a_phase_range, aclk, aresetn, phase_reg <= PH_TIMEOUT, "phase out of range")

endmodule

[rtl/core/kcef_obuf.sv]
// Two-entry result buffer between the state machine and the m_ channel.
// Depends on kcef_pkg and assert_macros.svh.
`include "assert_macros.svh"
module kcef_obuf
    import kcef_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    push,
    input  result_t push_data,
    output logic    can_push,
    output logic    out_valid,
    input  logic    out_ready,
    output result_t out_data
);

    logic [1:0] count_reg, count_next;
    result_t    head_reg;
    result_t    tail_reg;
    logic       pop;

    assign pop       = out_valid && out_ready;
    assign out_valid = count_reg != 2'd0;
    assign can_push  = count_reg != 2'd2;
    assign out_data  = head_reg;

    always_comb begin
        count_next = count_reg;
        case ({push, pop})
            2'b10:   count_next = count_reg + 2'd1;
            2'b01:   count_next = count_reg - 2'd1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= 2'd0;
        end else begin
            count_reg <= count_next;
        end
        if (pop && count_reg == 2'd2) begin
            head_reg <= tail_reg;
        end else if (push && (count_reg == 2'd0 || pop)) begin
            head_reg <= push_data;
        end
        if (push && !pop && count_reg == 2'd1) begin
            tail_reg <= push_data;
        end
    end

    `KCEF_ASSERT(a_no_overflow, aclk, aresetn, !(push && count_reg == 2'd2), "beat pushed into full buffer")
    `KCEF_ASSERT(a_no_underflow, aclk, aresetn, !(pop && count_reg == 2'd0), "beat popped from empty buffer")
    `KCEF_ASSERT(a_shift_tail, aclk, aresetn, (pop && count_reg == 2'd2) |=> (count_reg == 2'd1 && head_reg == $past(tail_reg)), "tail beat not advanced")

endmodule

[rtl/core/keypad_code_entry_fsm.sv]
// Keypad code entry: accepts one beat per cycle while s_ready is high and
// returns one registered result beat per input beat through a two-entry buffer.
// State is updated at the input handshake; s_ready drops only while two
// results wait, so throughput is one beat per cycle with m_ready high.
// Depends on kcef_pkg, kcef_core and kcef_obuf.
module keypad_code_entry_fsm
    import kcef_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_we,
    input  logic [TICK_W-1:0]  cfg_wdata,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic               s_req_type,
    input  logic [KEY_W-1:0]   s_key_code,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [PHASE_W-1:0] m_phase,
    output logic [COUNT_W-1:0] m_digits_held,
    output logic [CODE_W-1:0]  m_entered_code
);

    logic    accept;
    result_t res_next;
    result_t res_out;

    assign accept = s_valid && s_ready;

    kcef_core u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .item_en   (accept),
        .req_type  (s_req_type),
        .key_code  (s_key_code),
        .res_next  (res_next)
    );

    kcef_obuf u_obuf (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (accept),
        .push_data (res_next),
        .can_push  (s_ready),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_data  (res_out)
    );

    assign m_phase        = res_out.phase;
    assign m_digits_held  = res_out.digits_held;
    assign m_entered_code = res_out.entered_code;

endmodule
